@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/sst_pkg.sv @@
// ---------------------------------------------------------------------------
// sst_pkg
// types and codes shared by the sorted set table
// ---------------------------------------------------------------------------
package sst_pkg;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 3;
    localparam int OPCODE_W = 2;

    localparam logic [OPCODE_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READOUT = 2'd2;
    // dropped without a beat
    localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef enum logic
    {
        S_IDLE,
        S_WALK
    } state_t;

endpackage

@@ src/sst_ram.sv @@
// ---------------------------------------------------------------------------
// sst_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/sorted_set_table.sv @@
// ---------------------------------------------------------------------------
// sorted_set_table
// bounded ascending set of distinct signed 32-bit values held in a ram
// ---------------------------------------------------------------------------
// input beat: tuser carries the opcode (insert, delete, readout), tdata the
// value. output beats carry the value, the entry count after the operation,
// a status code in tuser and tlast on the final beat of each command.
// one command is worked at a time: s_axis_tready is high while no command is
// in progress. each command walks the ram from entry 0, one entry a cycle while the
// receiver does not stall, reading ahead and writing back the shifted entry behind the read.
// insert and delete each give their single result at the end of the walk.
// readout: count beats, one beat a cycle while the receiver does not stall, or
// one empty beat on an empty table. the single ram port pair sets this rate.
// results go through an output register, so a new command is accepted while
// the last beat still waits. a stall of the receiver holds the walk.
// reset empties the table at once (entry count to zero, no clearing pass);
// opcode 3 is dropped without a beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_set_table #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value[31:0]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value_out[31:0], entry_count[37:32], zero pad
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    sst_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                         count_reg, count_next;
    logic [CW-1:0]                         idx_reg, idx_next;
    logic                                  shift_reg, shift_next;
    logic [sst_pkg::OPCODE_W-1:0]          op_reg, op_next;
    logic signed [sst_pkg::VALUE_W-1:0]    val_reg, val_next;
    logic signed [sst_pkg::VALUE_W-1:0]    carry_reg, carry_next;

    logic                                  out_valid_reg, out_valid_next;
    logic signed [sst_pkg::VALUE_W-1:0]    out_value_reg, out_value_next;
    logic [CW-1:0]                         out_count_reg, out_count_next;
    logic [sst_pkg::STATUS_W-1:0]          out_status_reg, out_status_next;
    logic                                  out_last_reg, out_last_next;

    logic                                  ram_we;
    logic [AW-1:0]                         ram_waddr;
    logic [sst_pkg::VALUE_W-1:0]           ram_wdata;
    logic [AW-1:0]                         ram_raddr;
    logic [sst_pkg::VALUE_W-1:0]           ram_rdata;

    logic signed [sst_pkg::VALUE_W-1:0]    rd;
    logic                                  adv;
    logic                                  at_end;
    logic                                  in_acc;
    logic [CW-1:0]                         rd_idx;
    logic [CW-1:0]                         idx_prev;
    logic [CW+sst_pkg::COUNT_W-1:0]        count_ext;

    sst_ram #(
        .WIDTH (sst_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd       = $signed(ram_rdata);
    assign adv      = !out_valid_reg || m_axis_tready;
    assign at_end   = (idx_reg == count_reg);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign idx_prev = idx_reg - 1'b1;

    assign s_axis_tready = (state_reg == sst_pkg::S_IDLE);

    // read one entry ahead while walking; hold the address on a stall
    always_comb
    begin
        if (state_reg == sst_pkg::S_WALK && adv)
        begin
            rd_idx = idx_reg + 1'b1;
        end
        else if (state_reg == sst_pkg::S_WALK)
        begin
            rd_idx = idx_reg;
        end
        else
        begin
            rd_idx = '0;
        end
        ram_raddr = (rd_idx < CAP_C) ? rd_idx[AW-1:0] : '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sst_pkg::S_IDLE:
            begin
                if (in_acc && s_axis_tuser != sst_pkg::OP_UNUSED)
                begin
                    state_next = sst_pkg::S_WALK;
                end
            end
            sst_pkg::S_WALK:
            begin
                if (adv)
                begin
                    priority if (at_end)
                    begin
                        state_next = sst_pkg::S_IDLE;
                    end
                    else if (op_reg == sst_pkg::OP_READOUT)
                    begin
                        if (idx_reg + 1'b1 == count_reg)
                        begin
                            state_next = sst_pkg::S_IDLE;
                        end
                    end
                    else if (!shift_reg && rd == val_reg)
                    begin
                        // duplicate insert ends here; delete starts shifting
                        if (op_reg == sst_pkg::OP_INSERT)
                        begin
                            state_next = sst_pkg::S_IDLE;
                        end
                    end
                    else if (!shift_reg && rd > val_reg)
                    begin
                        if (op_reg == sst_pkg::OP_DELETE || count_reg == CAP_C)
                        begin
                            state_next = sst_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = state_reg;
                    end
                end
            end
            default:
            begin
                state_next = sst_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        shift_next      = shift_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        carry_next      = carry_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[AW-1:0];
        ram_wdata       = carry_reg;

        unique case (state_reg)
            sst_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next    = s_axis_tuser;
                    val_next   = $signed(s_axis_tdata);
                    carry_next = $signed(s_axis_tdata);
                    idx_next   = '0;
                    shift_next = 1'b0;
                end
            end
            sst_pkg::S_WALK:
            begin
                if (adv)
                begin
                    out_value_next = val_reg;
                    out_count_next = count_reg;
                    out_last_next  = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    unique case (op_reg)
                        sst_pkg::OP_READOUT:
                        begin
                            out_valid_next = 1'b1;
                            if (at_end)
                            begin
                                out_value_next  = '0;
                                out_status_next = sst_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                out_value_next  = rd;
                                out_status_next = sst_pkg::ST_DONE;
                                out_last_next   = (idx_reg + 1'b1 == count_reg);
                            end
                        end
                        sst_pkg::OP_INSERT:
                        begin
                            priority if (at_end)
                            begin
                                out_valid_next = 1'b1;
                                if (!shift_reg && count_reg == CAP_C)
                                begin
                                    out_status_next = sst_pkg::ST_FULL;
                                end
                                else
                                begin
                                    ram_we          = 1'b1;
                                    count_next      = count_reg + 1'b1;
                                    out_count_next  = count_reg + 1'b1;
                                    out_status_next = sst_pkg::ST_DONE;
                                end
                            end
                            else if (shift_reg)
                            begin
                                // ripple the displaced entry one place up
                                ram_we     = 1'b1;
                                carry_next = rd;
                            end
                            else if (rd == val_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = sst_pkg::ST_DUP;
                            end
                            else if (rd > val_reg)
                            begin
                                if (count_reg == CAP_C)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = sst_pkg::ST_FULL;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    ram_wdata  = val_reg;
                                    carry_next = rd;
                                    shift_next = 1'b1;
                                end
                            end
                            else
                            begin
                                shift_next = 1'b0;
                            end
                        end
                        sst_pkg::OP_DELETE:
                        begin
                            priority if (at_end)
                            begin
                                out_valid_next = 1'b1;
                                if (shift_reg)
                                begin
                                    count_next      = count_reg - 1'b1;
                                    out_count_next  = count_reg - 1'b1;
                                    out_status_next = sst_pkg::ST_DONE;
                                end
                                else
                                begin
                                    out_status_next = sst_pkg::ST_NOT_FOUND;
                                end
                            end
                            else if (shift_reg)
                            begin
                                // close the gap one place behind the read
                                ram_we    = 1'b1;
                                ram_waddr = idx_prev[AW-1:0];
                                ram_wdata = rd;
                            end
                            else if (rd == val_reg)
                            begin
                                shift_next = 1'b1;
                            end
                            else if (rd > val_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = sst_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                shift_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            idx_next = idx_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sst_pkg::S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            shift_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            shift_reg     <= shift_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        carry_reg      <= carry_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign count_ext     = {{sst_pkg::COUNT_W{1'b0}}, out_count_reg};
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, count_ext[sst_pkg::COUNT_W-1:0], out_value_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CAP_C, "entry count beyond capacity")
    `ASSERT_IMPL(a_walk_bound, state_reg == sst_pkg::S_WALK, idx_reg <= count_reg, "walk past fill")
    `ASSERT_NEXT(a_idle_count, state_reg == sst_pkg::S_IDLE, $stable(count_reg), "count moved idle")

endmodule
